// ===== design/ffs_pkg.sv =====
// shared types, constants, saturating add and correction table for the forward scorer
package ffs_pkg;

  localparam int SCORE_WIDTH        = 32;
  localparam int FRACTION_BITS      = 16;
  localparam int MAX_POSITIONS      = 1024;
  localparam int CORRECTION_ENTRIES = 256;

  localparam int POS_W       = $clog2(MAX_POSITIONS);
  localparam int CORR_IDX_W  = $clog2(CORRECTION_ENTRIES);
  localparam int STEP_SHIFT  = FRACTION_BITS - 4;
  localparam int IDX_TOP     = STEP_SHIFT + CORR_IDX_W;

  localparam logic [63:0] Q30_ONE      = 64'd1 << 30;
  localparam logic [63:0] EXP_STEP_Q30 = 64'd1008687095;
  localparam logic [63:0] ROUND_HALF   = 64'd1 << (30 - FRACTION_BITS - 1);

  typedef logic signed [SCORE_WIDTH-1:0] score_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [CORR_IDX_W-1:0] corr_idx_t;
  typedef score_t corr_table_t [CORRECTION_ENTRIES];

  localparam score_t SCORE_MIN = score_t'({1'b1, {(SCORE_WIDTH-1){1'b0}}});
  localparam score_t SCORE_MAX = score_t'({1'b0, {(SCORE_WIDTH-1){1'b1}}});
  localparam pos_t   POS_LAST  = pos_t'(MAX_POSITIONS - 1);

  // per-item control that travels down the pipeline
  typedef struct packed {
    logic first;
    logic done;
    logic send;
    pos_t pos;
  } item_ctl_t;

  // stage loads handed to the log-add unit
  typedef struct packed {
    logic load_diff;
    logic load_sum;
  } la_load_t;

  // saturating add, floor operand forces floor
  function automatic score_t sat_add(score_t a, score_t b);
    logic signed [SCORE_WIDTH:0] sum;
    score_t res;
    sum = $signed({a[SCORE_WIDTH-1], a}) + $signed({b[SCORE_WIDTH-1], b});
    if (a == SCORE_MIN || b == SCORE_MIN) begin
      res = SCORE_MIN;
    end else if (sum[SCORE_WIDTH] != sum[SCORE_WIDTH-1]) begin
      res = sum[SCORE_WIDTH] ? SCORE_MIN : SCORE_MAX;
    end else begin
      res = score_t'(sum[SCORE_WIDTH-1:0]);
    end
    return res;
  endfunction

  // shift-subtract quotient, elaboration use only
  function automatic logic [63:0] const_udiv(logic [63:0] num, logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // ln(1+y), y and result in q30, via 2*atanh(y/(2+y))
  function automatic logic [63:0] ln1p_q30(logic [63:0] y);
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] p;
    logic [63:0] sum;
    z   = const_udiv(y << 30, (Q30_ONE << 1) + y);
    z2  = (z * z) >> 30;
    p   = z;
    sum = '0;
    for (int k = 0; k < 12; k++) begin
      sum = sum + const_udiv(p, 64'(2 * k + 1));
      p   = (p * z2) >> 30;
    end
    return sum << 1;
  endfunction

  // entry i = ln(1 + exp(-i/16)) rounded to the score fraction
  function automatic corr_table_t build_corr_table();
    corr_table_t tbl;
    logic [63:0] y;
    logic [63:0] l;
    y = Q30_ONE;
    for (int i = 0; i < CORRECTION_ENTRIES; i++) begin
      l      = ln1p_q30(y);
      tbl[i] = score_t'((l + ROUND_HALF) >> (30 - FRACTION_BITS));
      y      = (y * EXP_STEP_Q30) >> 30;
    end
    return tbl;
  endfunction

  localparam corr_table_t CORR_TABLE = build_corr_table();

endpackage

// ===== design/forced_alignment_forward_score.sv =====
// top level: streaming forced-alignment forward (alpha) scorer
//
// input channel (in_valid / in_ready) takes one lattice cell per item, frame
// by frame, positions 0,1,2,... within a frame; frame_end marks the last
// position of a frame and sequence_end the last item of a sequence.
// output channel (out_valid / out_ready) gives one result per item, in order:
// alpha_score, its position, column_done and score_ready.
// an accepted item passes stages 1 to 4 and stage 5 before its result shows on
// the output register. throughput is one item per cycle while frames hold at
// least 5 positions and the receiver does not stall; the previous column lives
// in a ram with registered read data, and an item whose column entry is still
// being computed by an item in flight (frames shorter than 5 positions) waits
// at the input until that write lands.
// reset (synchronous) empties the pipeline, sets the position counter to 0
// and the left-neighbor hold to minus infinity; the column ram is not cleared.
// when the receiver stalls, results pile up in the pipeline stages; the input
// keeps accepting until every stage is full, then in_ready drops.
module forced_alignment_forward_score (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ffs_pkg::score_t      emission_score,
  input  ffs_pkg::score_t      self_score,
  input  ffs_pkg::score_t      enter_score,
  input  logic                 first_frame,
  input  logic                 frame_end,
  input  logic                 sequence_end,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ffs_pkg::score_t      alpha_score,
  output ffs_pkg::pos_t        position,
  output logic                 column_done,
  output logic                 score_ready
);

  // pipeline occupancy and stage loads
  logic s1_valid, s2_valid, s3_valid, s4_valid;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic ld1, ld2, ld3, ld4, ld5;
  logic hazard;

  // position counter and left-neighbor hold
  ffs_pkg::pos_t   position_count;
  ffs_pkg::pos_t   position_count_next;
  ffs_pkg::score_t held_left;
  ffs_pkg::score_t held_left_next;

  // stage payloads
  ffs_pkg::item_ctl_t in_ctl;
  ffs_pkg::item_ctl_t s1_ctl, s2_ctl, s3_ctl, s4_ctl;
  ffs_pkg::score_t    s1_em, s2_em, s3_em, s4_em;
  ffs_pkg::score_t    s1_self, s1_enter;
  ffs_pkg::score_t    s2_a, s2_b;
  ffs_pkg::score_t    s4_la;
  ffs_pkg::score_t    prev;
  ffs_pkg::score_t    alpha;
  ffs_pkg::la_load_t  la_load;

  // elastic pipeline: a stage loads when it is empty or draining
  assign rdy5 = !out_valid || out_ready;
  assign rdy4 = !s4_valid || rdy5;
  assign rdy3 = !s3_valid || rdy4;
  assign rdy2 = !s2_valid || rdy3;
  assign rdy1 = !s1_valid || rdy2;

  // interlock: the entry this item reads is still owed by an item in flight
  assign hazard = (s1_valid && s1_ctl.pos == position_count) ||
                  (s2_valid && s2_ctl.pos == position_count) ||
                  (s3_valid && s3_ctl.pos == position_count) ||
                  (s4_valid && s4_ctl.pos == position_count);

  assign in_ready = rdy1 && !hazard;
  assign ld1 = in_valid && in_ready;
  assign ld2 = s1_valid && rdy2;
  assign ld3 = s2_valid && rdy3;
  assign ld4 = s3_valid && rdy4;
  assign ld5 = s4_valid && rdy5;

  assign in_ctl.first = first_frame;
  assign in_ctl.done  = frame_end || sequence_end;
  assign in_ctl.send  = sequence_end;
  assign in_ctl.pos   = position_count;

  always_comb begin
    position_count_next = position_count;
    if (ld1) begin
      if (in_ctl.done || position_count == ffs_pkg::POS_LAST) begin
        position_count_next = '0;
      end else begin
        position_count_next = position_count + 1'b1;
      end
    end
  end

  // held_left keeps the previous frame's value one position to the left
  always_comb begin
    held_left_next = held_left;
    if (ld2) begin
      held_left_next = (s1_ctl.done || s1_ctl.first) ? ffs_pkg::SCORE_MIN : prev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      s2_valid       <= 1'b0;
      s3_valid       <= 1'b0;
      s4_valid       <= 1'b0;
      out_valid      <= 1'b0;
      position_count <= '0;
      held_left      <= ffs_pkg::SCORE_MIN;
    end else begin
      s1_valid       <= ld1 || (s1_valid && !ld2);
      s2_valid       <= ld2 || (s2_valid && !ld3);
      s3_valid       <= ld3 || (s3_valid && !ld4);
      s4_valid       <= ld4 || (s4_valid && !ld5);
      out_valid      <= ld5 || (out_valid && !out_ready);
      position_count <= position_count_next;
      held_left      <= held_left_next;
    end
  end

  // previous column, read at accept, written when a result is formed
  ffs_ram #(
    .WIDTH(ffs_pkg::SCORE_WIDTH),
    .DEPTH(ffs_pkg::MAX_POSITIONS)
  ) u_column_store (
    .clk  (clk),
    .we   (ld5),
    .waddr(s4_ctl.pos),
    .wdata(alpha),
    .re   (ld1),
    .raddr(position_count),
    .rdata(prev)
  );

  // stage 1: item registered, column entry arriving from the ram
  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_ctl   <= in_ctl;
      s1_em    <= emission_score;
      s1_self  <= self_score;
      s1_enter <= enter_score;
    end
  end

  // stage 2: stay and diagonal path sums
  always_ff @(posedge clk) begin
    if (ld2) begin
      s2_ctl <= s1_ctl;
      s2_em  <= s1_em;
      s2_a   <= ffs_pkg::sat_add(prev, s1_self);
      s2_b   <= ffs_pkg::sat_add(held_left, s1_enter);
    end
  end

  // stages 3 and 4: log-add of the two paths (position 0 keeps the stay path)
  assign la_load.load_diff = ld3;
  assign la_load.load_sum  = ld4;

  ffs_logadd u_logadd (
    .clk (clk),
    .load(la_load),
    .a   (s2_a),
    .b   (s2_b),
    .diag(s2_ctl.pos != '0),
    .sum (s4_la)
  );

  always_ff @(posedge clk) begin
    if (ld3) begin
      s3_ctl <= s2_ctl;
      s3_em  <= s2_em;
    end
    if (ld4) begin
      s4_ctl <= s3_ctl;
      s4_em  <= s3_em;
    end
  end

  // stage 5: emission added, first frame seeds position 0 only
  always_comb begin
    if (s4_ctl.first) begin
      alpha = (s4_ctl.pos == '0) ? s4_em : ffs_pkg::SCORE_MIN;
    end else begin
      alpha = ffs_pkg::sat_add(s4_em, s4_la);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (ld5) begin
      alpha_score <= alpha;
      position    <= s4_ctl.pos;
      column_done <= s4_ctl.done;
      score_ready <= s4_ctl.send;
    end
  end

endmodule

// ===== design/ffs_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
module ffs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/ffs_logadd.sv =====
// two-stage log-add: order and distance, then correction lookup and add
module ffs_logadd (
  input  logic              clk,
  input  ffs_pkg::la_load_t load,
  input  ffs_pkg::score_t   a,
  input  ffs_pkg::score_t   b,
  input  logic              diag,
  output ffs_pkg::score_t   sum
);

  ffs_pkg::score_t   hi;
  ffs_pkg::score_t   lo;
  logic [ffs_pkg::SCORE_WIDTH-1:0] diff;
  logic              use_corr;

  ffs_pkg::score_t   hi_reg;
  ffs_pkg::corr_idx_t idx_reg;
  logic              use_reg;
  ffs_pkg::score_t   corr;

  always_comb begin
    hi       = a;
    lo       = b;
    use_corr = 1'b0;
    if (diag && a != ffs_pkg::SCORE_MIN && b != ffs_pkg::SCORE_MIN) begin
      if (a > b) begin
        hi = a;
        lo = b;
      end else begin
        hi = b;
        lo = a;
      end
      use_corr = 1'b1;
    end else if (diag && a == ffs_pkg::SCORE_MIN) begin
      hi = b;
    end
    diff = unsigned'(hi) - unsigned'(lo);
  end

  always_ff @(posedge clk) begin
    if (load.load_diff) begin
      hi_reg  <= hi;
      idx_reg <= diff[ffs_pkg::IDX_TOP-1:ffs_pkg::STEP_SHIFT];
      use_reg <= use_corr && (diff[ffs_pkg::SCORE_WIDTH-1:ffs_pkg::IDX_TOP] == '0);
    end
  end

  assign corr = use_reg ? ffs_pkg::CORR_TABLE[idx_reg] : '0;

  always_ff @(posedge clk) begin
    if (load.load_sum) begin
      sum <= ffs_pkg::sat_add(hi_reg, corr);
    end
  end

endmodule

// ===== design/ffs_checker.sv =====
// port-level checker for the forward scorer, bound to the top level
module ffs_checker (
  input logic            clk,
  input logic            rst,
  input logic            out_valid,
  input logic            out_ready,
  input ffs_pkg::score_t alpha_score,
  input ffs_pkg::pos_t   position,
  input logic            column_done,
  input logic            score_ready
);

  ffs_pkg::pos_t exp_pos;

  // expected position of the next result
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_pos <= '0;
    end else if (out_valid && out_ready) begin
      if (column_done || position == ffs_pkg::POS_LAST) begin
        exp_pos <= '0;
      end else begin
        exp_pos <= position + 1'b1;
      end
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(alpha_score) && $stable(position))
    else $error("stalled result changed");

  a_final_ends_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && score_ready |-> column_done)
    else $error("final score without frame end");

  a_position_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> position == exp_pos)
    else $error("result position out of order");

endmodule

bind forced_alignment_forward_score ffs_checker u_ffs_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .alpha_score(alpha_score),
  .position   (position),
  .column_done(column_done),
  .score_ready(score_ready)
);
